[rtl/rre_pkg.sv]
// Shared types and constants of the retransmission timeout estimator.
// No dependencies; every other file imports this package.
package rre_pkg;

   localparam int RtoWidth   = 31;
   localparam int TimeWidth  = 32;
   localparam int CountWidth = 8;
   localparam int StateWidth = 40;
   localparam int CsrIdxWidth = 2;

   localparam logic [1:0] MODE_REINIT   = 2'd0;
   localparam logic [1:0] MODE_RESPONSE = 2'd1;
   localparam logic [1:0] MODE_TIMEOUT  = 2'd2;

   localparam logic [CsrIdxWidth-1:0] CSR_RTO_MIN         = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RTO_MAX         = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_RETRANSMITS = 2'd2;

   localparam logic [RtoWidth-1:0]   RTO_MIN_RESET   = 31'd1000;
   localparam logic [RtoWidth-1:0]   RTO_MAX_RESET   = 31'd3000;
   localparam logic [CountWidth-1:0] MAX_RETX_RESET  = 8'd12;
   localparam logic signed [StateWidth-1:0] INIT_DEV_X4 = 40'sd3000;
   localparam logic [RtoWidth-1:0]   RTO_RESET       = 31'd3000;

   typedef struct packed {
      logic [1:0]            mode;
      logic [TimeWidth-1:0]  now_time;
      logic [TimeWidth-1:0]  sent_time;
      logic [CountWidth-1:0] retransmit_count;
   } req_type;

   typedef struct packed {
      logic [RtoWidth-1:0]         timeout_ms;
      logic                        give_up;
      logic signed [TimeWidth-1:0] measured_rtt;
   } rsp_type;

   typedef struct packed {
      logic [RtoWidth-1:0]   rto_min;
      logic [RtoWidth-1:0]   rto_max;
      logic [CountWidth-1:0] max_retransmits;
   } cfg_type;

   function automatic logic [RtoWidth-1:0] clamp_rto(
      input logic signed [StateWidth+1:0] value,
      input logic [RtoWidth-1:0]          lo,
      input logic [RtoWidth-1:0]          hi
   );
      logic signed [StateWidth+1:0] lo_ext;
      logic signed [StateWidth+1:0] hi_ext;
      lo_ext = signed'({11'b0, lo});
      hi_ext = signed'({11'b0, hi});
      if (value < lo_ext) begin
         return lo;
      end else if (value > hi_ext) begin
         return hi;
      end
      return value[RtoWidth-1:0];
   endfunction

endpackage

[rtl/rre_if.sv]
// Valid/ready channel interfaces for request and response beats.
// Depends on rre_pkg.
interface rre_req_if;
   import rre_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rre_rsp_if;
   import rre_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/rre_cfg_regs.sv]
// Limit registers written through the csr port.
// Depends on rre_pkg.
module rre_cfg_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [rre_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [rre_pkg::RtoWidth-1:0]         csr_wdata,
   output rre_pkg::cfg_type                     cfg
);
   import rre_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RTO_MIN:         cfg_in.rto_min = csr_wdata;
            CSR_RTO_MAX:         cfg_in.rto_max = csr_wdata;
            CSR_MAX_RETRANSMITS: cfg_in.max_retransmits = csr_wdata[CountWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rto_min         <= RTO_MIN_RESET;
         cfg_ff.rto_max         <= RTO_MAX_RESET;
         cfg_ff.max_retransmits <= MAX_RETX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/rre_core.sv]
// Estimator state and its per-event update; result is combinational.
// Depends on rre_pkg.
module rre_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  rre_pkg::req_type item,
   input  rre_pkg::cfg_type cfg,
   output rre_pkg::rsp_type result
);
   import rre_pkg::*;

   logic signed [StateWidth-1:0] srtt_ff, srtt_in;
   logic signed [StateWidth-1:0] dev_ff, dev_in;
   logic [RtoWidth-1:0]          rto_ff, rto_in;
   logic signed [TimeWidth-1:0]  rtt_ff, rtt_in;
   logic                         give_up;

   logic signed [TimeWidth-1:0]    rtt;
   logic signed [StateWidth:0]     delta;
   logic signed [StateWidth:0]     delta_abs;
   logic signed [StateWidth-1:0]   srtt_new;
   logic signed [StateWidth-1:0]   dev_new;
   logic signed [StateWidth-1:0]   srtt_div8;
   logic signed [StateWidth+1:0]   rto_raw;
   logic signed [StateWidth+1:0]   rto_dbl;
   logic signed [StateWidth+1:0]   rto_init;

   always_comb begin
      rtt       = signed'(item.now_time - item.sent_time);
      srtt_div8 = srtt_ff >>> 3;
      delta     = StateWidth'(0) + {{(StateWidth+1-TimeWidth){rtt[TimeWidth-1]}}, rtt}
                  - {srtt_div8[StateWidth-1], srtt_div8};
      delta_abs = delta[StateWidth] ? -delta : delta;
      srtt_new  = srtt_ff + delta[StateWidth-1:0];
      dev_new   = dev_ff + delta_abs[StateWidth-1:0] - (dev_ff >>> 2);
      rto_raw   = {{2{srtt_new[StateWidth-1]}}, srtt_new >>> 3}
                  + {{2{dev_new[StateWidth-1]}}, dev_new};
      rto_dbl   = signed'({11'b0, rto_ff} <<< 1);
      rto_init  = {{2{INIT_DEV_X4[StateWidth-1]}}, INIT_DEV_X4};

      srtt_in = srtt_ff;
      dev_in  = dev_ff;
      rto_in  = rto_ff;
      rtt_in  = rtt_ff;
      give_up = 1'b0;
      unique case (item.mode)
         MODE_REINIT: begin
            srtt_in = '0;
            dev_in  = INIT_DEV_X4;
            rtt_in  = '0;
            rto_in  = clamp_rto(rto_init, cfg.rto_min, cfg.rto_max);
         end
         MODE_RESPONSE: begin
            srtt_in = srtt_new;
            dev_in  = dev_new;
            rtt_in  = rtt;
            rto_in  = clamp_rto(rto_raw, cfg.rto_min, cfg.rto_max);
         end
         MODE_TIMEOUT: begin
            rto_in  = clamp_rto(rto_dbl, cfg.rto_min, cfg.rto_max);
            give_up = (item.retransmit_count >= cfg.max_retransmits);
         end
         default: begin
            give_up = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff <= '0;
         dev_ff  <= INIT_DEV_X4;
         rto_ff  <= RTO_RESET;
         rtt_ff  <= '0;
      end else if (advance) begin
         srtt_ff <= srtt_in;
         dev_ff  <= dev_in;
         rto_ff  <= rto_in;
         rtt_ff  <= rtt_in;
      end
   end

   assign result.timeout_ms   = rto_in;
   assign result.give_up      = give_up;
   assign result.measured_rtt = rtt_in;

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(srtt_ff) && $stable(dev_ff) && $stable(rto_ff) && $stable(rtt_ff))
      else $error("state changed without an event");

   a_reinit: assert property (@(posedge clock) disable iff (reset)
      advance && item.mode == MODE_REINIT |=> srtt_ff == '0 && dev_ff == INIT_DEV_X4
                                              && rtt_ff == '0)
      else $error("reinit left stale state");

   a_give_up_timeout: assert property (@(posedge clock) disable iff (reset)
      give_up |-> item.mode == MODE_TIMEOUT)
      else $error("give_up outside a timeout event");

endmodule

[rtl/rtt_rto_estimator.sv]
// Top level of the retransmission timeout estimator: input stage, core,
// result register and limit registers. Depends on rre_pkg, rre_if,
// rre_cfg_regs and rre_core.
//
// Usage: each req beat carries one event (mode 0 reinit, 1 response with
// now/sent timestamps, 2 timeout with retransmit count). Each event gives
// exactly one rsp beat with the timeout after the event, the give_up flag
// and the last measured round trip time.
// The rsp beat passes two registers: the input register loads when its req beat
// is accepted, and the result register loads when the core advances.
// Throughput: one beat per cycle while rsp.ready is high; the whole estimator
// update is combinational between the two registers.
// csr writes set rto_min (index 0), rto_max (1) and max_retransmits (2);
// they take effect at the next event and do not re-clamp the timeout.
// Reset (synchronous, active high) empties both stages, loads the limit
// defaults 1000/3000/12 and sets the timeout to 3000 ms.
// When rsp.ready is low, the result holds and the input stage keeps one
// more beat; req.ready drops once both are full.
module rtt_rto_estimator (
   input  logic                            clock,
   input  logic                            reset,
   rre_req_if.sink                         req,
   rre_rsp_if.source                       rsp,
   input  logic                            csr_wr_en,
   input  logic [rre_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [rre_pkg::RtoWidth-1:0]    csr_wdata
);
   import rre_pkg::*;

   logic    stg_valid_ff;
   req_type stg_item_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    advance;
   cfg_type cfg;
   rsp_type result;

   rre_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rre_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stg_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance   = stg_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !stg_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            stg_valid_ff <= req.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         stg_item_ff <= req.data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register lost a beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !advance)
      else $error("stalled result overwritten");

endmodule

[bench/testbench.sv]
// Self-checking bench for rtt_rto_estimator: random and directed events through
// valid/ready channels, predicted in-bench and compared beat by beat.
// Depends on rre_pkg, rre_if and the RTL top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rre_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [RtoWidth-1:0] RTO_TOP = 31'h7FFF_FFFF;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [RtoWidth-1:0] csr_wdata;

   rre_req_if req_ch ();
   rre_rsp_if rsp_ch ();

   rtt_rto_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // estimator state and limits as the block should hold them
   logic signed [StateWidth-1:0] est_srtt_x8;
   logic signed [StateWidth-1:0] est_dev_x4;
   logic [RtoWidth-1:0]          est_timeout;
   logic signed [TimeWidth-1:0]  est_last_rtt;
   logic [RtoWidth-1:0]          lim_rto_min;
   logic [RtoWidth-1:0]          lim_rto_max;
   logic [CountWidth-1:0]        lim_max_retx;

   req_type events_waiting[$];
   rsp_type estimates_due[$];

   logic req_beat = 1'b0;
   bit   calm;
   int   send_gap;
   int   rsp_stall;
   int   hold_requests;
   int   holds_done;
   int   mismatches;
   int   n_reinit, n_resp, n_tmo, n_giveup, n_unused, n_settings;
   logic [TimeWidth-1:0] flow_ms;

   function automatic logic [RtoWidth-1:0] bound_timeout(input longint v);
      if (v < longint'(lim_rto_min)) begin
         return lim_rto_min;
      end else if (v > longint'(lim_rto_max)) begin
         return lim_rto_max;
      end
      return v[RtoWidth-1:0];
   endfunction

   function automatic rsp_type estimate_event(input req_type e);
      rsp_type r;
      longint  rtt, delta, srtt, dev;
      logic    quit;
      quit = 1'b0;
      case (e.mode)
         MODE_REINIT: begin
            est_srtt_x8  = '0;
            est_dev_x4   = INIT_DEV_X4;
            est_last_rtt = '0;
            est_timeout  = bound_timeout(longint'(INIT_DEV_X4));
         end
         MODE_RESPONSE: begin
            rtt = longint'($signed(e.now_time - e.sent_time));
            srtt = longint'(est_srtt_x8);
            dev = longint'(est_dev_x4);
            delta = rtt - (srtt >>> 3);
            srtt = srtt + delta;
            if (delta < 0) begin
               delta = -delta;
            end
            dev = dev + delta - (dev >>> 2);
            est_srtt_x8  = srtt[StateWidth-1:0];
            est_dev_x4   = dev[StateWidth-1:0];
            est_last_rtt = rtt[TimeWidth-1:0];
            est_timeout  = bound_timeout((srtt >>> 3) + dev);
         end
         MODE_TIMEOUT: begin
            est_timeout = bound_timeout(longint'(est_timeout) * 2);
            quit = (e.retransmit_count >= lim_max_retx);
         end
         default: begin
         end
      endcase
      r.timeout_ms   = est_timeout;
      r.give_up      = quit;
      r.measured_rtt = est_last_rtt;
      return r;
   endfunction

   function automatic req_type make_req(input logic [1:0] mode, input logic [31:0] now_t,
                                        input logic [31:0] sent_t, input logic [7:0] cnt);
      req_type e;
      e.mode             = mode;
      e.now_time         = now_t;
      e.sent_time        = sent_t;
      e.retransmit_count = cnt;
      return e;
   endfunction

   function automatic int gap_len();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_beat)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (events_waiting.size() != 0) begin
            req_ch.valid <= 1'b1;
            req_ch.data  <= events_waiting.pop_front();
            send_gap = gap_len();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_stall = 150;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_stall = gap_len();
         end
      end
   end

   always @(posedge clock) begin : watch_beats
      rsp_type want;
      rsp_type got;
      req_beat <= req_ch.valid && req_ch.ready && !reset;
      if (!reset && req_ch.valid && req_ch.ready) begin
         want = estimate_event(req_ch.data);
         estimates_due.push_back(want);
         case (req_ch.data.mode)
            MODE_REINIT:   n_reinit++;
            MODE_RESPONSE: n_resp++;
            MODE_TIMEOUT:  n_tmo++;
            default:       n_unused++;
         endcase
         if (want.give_up) begin
            n_giveup++;
         end
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (estimates_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat, timeout_ms %0d give_up %0b rtt %0d",
                     $time, got.timeout_ms, got.give_up, got.measured_rtt);
         end else begin
            want = estimates_due.pop_front();
            if (got.timeout_ms !== want.timeout_ms) begin
               mismatches++;
               $display("%0t: timeout_ms expected %0d, actual %0d",
                        $time, want.timeout_ms, got.timeout_ms);
            end
            if (got.give_up !== want.give_up) begin
               mismatches++;
               $display("%0t: give_up expected %0b, actual %0b",
                        $time, want.give_up, got.give_up);
            end
            if (got.measured_rtt !== want.measured_rtt) begin
               mismatches++;
               $display("%0t: measured_rtt expected %0d, actual %0d",
                        $time, want.measured_rtt, got.measured_rtt);
            end
         end
      end
   end

   task automatic csr_write(input logic [CsrIdxWidth-1:0] idx, input logic [RtoWidth-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_RTO_MIN:         lim_rto_min  = val;
         CSR_RTO_MAX:         lim_rto_max  = val;
         CSR_MAX_RETRANSMITS: lim_max_retx = val[CountWidth-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic set_limits(input logic [RtoWidth-1:0] lo, input logic [RtoWidth-1:0] hi,
                             input logic [RtoWidth-1:0] retx);
      csr_write(CSR_RTO_MIN, lo);
      csr_write(CSR_RTO_MAX, hi);
      csr_write(CSR_MAX_RETRANSMITS, retx);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   task automatic drain();
      while (events_waiting.size() != 0 || req_ch.valid || estimates_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_traffic(input int n);
      int r, k;
      logic [31:0] rtt, sent;
      int c;
      @(posedge clock);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            events_waiting.push_back(make_req(MODE_REINIT, $urandom, $urandom, 8'($urandom)));
         end else if (r < 7) begin
            events_waiting.push_back(make_req(MODE_UNUSED, $urandom, $urandom, 8'($urandom)));
         end else if (r < 27) begin
            if ($urandom_range(0, 1)) begin
               c = int'(lim_max_retx) + $urandom_range(0, 4) - 2;
               c = (c < 0) ? 0 : (c > 255) ? 255 : c;
            end else begin
               c = $urandom_range(0, 255);
            end
            events_waiting.push_back(make_req(MODE_TIMEOUT, $urandom, $urandom, c[7:0]));
         end else begin
            flow_ms += $urandom_range(0, 500);
            sent = flow_ms;
            k = $urandom_range(0, 99);
            if (k < 70) begin
               rtt = $urandom_range(0, 3000);
            end else if (k < 85) begin
               rtt = $urandom_range(0, 200000);
            end else if (k < 93) begin
               rtt = -$urandom_range(1, 1000);
            end else begin
               sent = $urandom;
               rtt = $urandom;
            end
            events_waiting.push_back(make_req(MODE_RESPONSE, sent + rtt, sent, 8'($urandom)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_RTO_MIN;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      lim_rto_min = RTO_MIN_RESET;
      lim_rto_max = RTO_MAX_RESET;
      lim_max_retx = MAX_RETX_RESET;
      est_srtt_x8 = '0;
      est_dev_x4 = INIT_DEV_X4;
      est_timeout = RTO_RESET;
      est_last_rtt = '0;
      flow_ms = $urandom;
      calm = 1'b1;
      n_settings = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      events_waiting.push_back(make_req(MODE_RESPONSE, 32'd100, 32'd0, 8'd0));
      events_waiting.push_back(make_req(MODE_RESPONSE, 32'd0, 32'd1, 8'd0));
      events_waiting.push_back(make_req(MODE_RESPONSE, 32'h7FFF_FFFF, 32'd0, 8'd0));
      events_waiting.push_back(make_req(MODE_RESPONSE, 32'h8000_0000, 32'd0, 8'd0));
      events_waiting.push_back(make_req(MODE_RESPONSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      events_waiting.push_back(make_req(MODE_RESPONSE, 32'd5, 32'hFFFF_FFFB, 8'd0));
      events_waiting.push_back(make_req(MODE_TIMEOUT, 32'd0, 32'd0, 8'd0));
      events_waiting.push_back(make_req(MODE_TIMEOUT, 32'd0, 32'd0, 8'd11));
      events_waiting.push_back(make_req(MODE_TIMEOUT, 32'd0, 32'd0, 8'd12));
      events_waiting.push_back(make_req(MODE_TIMEOUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255));
      events_waiting.push_back(make_req(MODE_UNUSED, 32'hFFFF_FFFF, 32'd0, 8'hFF));
      events_waiting.push_back(make_req(MODE_REINIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      events_waiting.push_back(make_req(MODE_RESPONSE, 32'd250, 32'd0, 8'd0));
      events_waiting.push_back(make_req(MODE_RESPONSE, 32'd300, 32'd0, 8'd0));
      events_waiting.push_back(make_req(MODE_TIMEOUT, 32'd0, 32'd0, 8'd3));
      events_waiting.push_back(make_req(MODE_TIMEOUT, 32'd0, 32'd0, 8'd4));
      events_waiting.push_back(make_req(MODE_TIMEOUT, 32'd0, 32'd0, 8'd5));
      events_waiting.push_back(make_req(MODE_REINIT, 32'd0, 32'd0, 8'd0));
      events_waiting.push_back(make_req(MODE_RESPONSE, 32'd20, 32'd0, 8'd0));
      events_waiting.push_back(make_req(MODE_UNUSED, 32'd0, 32'd0, 8'd0));
      drain();

      calm = 1'b0;
      set_limits('0, RTO_TOP, '0);
      queue_traffic(150);
      drain();

      calm = 1'b1;
      set_limits(31'd200, 31'd60000, 31'd8);
      queue_traffic(160);
      hold_requests++;
      drain();

      calm = 1'b0;
      set_limits(31'd5000, 31'd100, 31'd255);
      queue_traffic(110);
      drain();

      set_limits(RTO_TOP, RTO_TOP, 31'd1);
      queue_traffic(90);
      drain();

      set_limits(31'($urandom_range(0, 5000)), 31'($urandom_range(0, 200000)),
                 31'($urandom));
      queue_traffic(160);
      drain();

      set_limits(31'($urandom_range(0, 2000)), 31'($urandom_range(2000, 500000)),
                 31'($urandom_range(0, 20)));
      queue_traffic(160);
      drain();
      repeat (10) @(negedge clock);

      $display("Covered %0d responses, %0d timeouts (%0d give-ups), %0d reinits, %0d unused",
               n_resp, n_tmo, n_giveup, n_reinit, n_unused);
      $display("across %0d limit settings, including inverted and full-range clamps",
               n_settings);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
rtl/rre_pkg.sv
rtl/rre_if.sv
rtl/rre_cfg_regs.sv
rtl/rre_core.sv
rtl/rtt_rto_estimator.sv
bench/testbench.sv
